// ===== hw/rtl/xrru_pkg.sv =====
`default_nettype none
package xrru_pkg;

    localparam int unsigned WORD_W          = 64;
    localparam int unsigned OP_W            = 3;
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned CFG_DATA_W      = 64;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [WORD_W-1:0] SEED_FALLBACK = 64'h1234567890abcdef;
    localparam logic [WORD_W-1:0] SEED_LOW_RST  = 64'h1234567890abcdef;
    localparam logic [WORD_W-1:0] SEED_HIGH_RST = 64'h0;

    localparam int unsigned SHIFT_A   = 23;
    localparam int unsigned SHIFT_B   = 17;
    localparam int unsigned SHIFT_C   = 26;
    localparam int unsigned FRAC_DROP = 11;

    localparam logic [7:0] UUID_VER_MASK = 8'h0f;
    localparam logic [7:0] UUID_VER      = 8'h40;
    localparam logic [7:0] UUID_VAR_MASK = 8'h3f;
    localparam logic [7:0] UUID_VAR      = 8'h80;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_HIGH = 1'b1;

    localparam logic [OP_W-1:0] OP_RAW   = 3'd0;
    localparam logic [OP_W-1:0] OP_BOOL  = 3'd1;
    localparam logic [OP_W-1:0] OP_RANGE = 3'd2;
    localparam logic [OP_W-1:0] OP_FRAC  = 3'd3;
    localparam logic [OP_W-1:0] OP_UUID  = 3'd4;

    typedef enum logic [2:0] {
        K_RAW,
        K_BOOL,
        K_RANGE,
        K_FRAC,
        K_UUID,
        K_ERR,
        K_NOP
    } t_kind;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] range_min;
        logic signed [WORD_W-1:0] range_max;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] uuid_high;
        logic [WORD_W-1:0] uuid_low;
        logic              range_error;
    } t_rsp;

    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] range_min;
        logic [WORD_W-1:0] span;
    } t_cmd;

    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < WORD_W / 8; k++) begin
            r[WORD_W-1-8*k -: 8] = w[8*k +: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/xrru_front.sv =====
`default_nettype none
module xrru_front
    import xrru_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_cmd_valid,
    input  wire logic i_cmd_full,
    output t_cmd      o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic push;
    logic take;

    assign push    = r_valid && !i_cmd_full;
    assign o_ready = !r_valid || push;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_cmd           = r_cmd;
        n_valid         = r_valid;
        if (push) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid         = 1'b1;
            n_cmd.range_min = i_req.range_min;
            n_cmd.span      = i_req.range_max - i_req.range_min;
            unique case (i_req.op)
                OP_RAW:   n_cmd.kind = K_RAW;
                OP_BOOL:  n_cmd.kind = K_BOOL;
                OP_RANGE: begin
                    if (i_req.range_max <= i_req.range_min) begin
                        n_cmd.kind = K_ERR;
                    end else begin
                        n_cmd.kind = K_RANGE;
                    end
                end
                OP_FRAC:  n_cmd.kind = K_FRAC;
                OP_UUID:  n_cmd.kind = K_UUID;
                default:  n_cmd.kind = K_NOP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = push;
    assign o_cmd       = r_cmd;

endmodule
`default_nettype wire

// ===== hw/rtl/xrru_queue.sv =====
`default_nettype none
module xrru_queue
    import xrru_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/xrru_back.sv =====
`default_nettype none
module xrru_back
    import xrru_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    input  wire t_cmd                  i_cmd,
    output logic                       o_cmd_pop,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_rsp                       o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DRAW = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [WORD_W-1:0] r_seed_low, n_seed_low;
    logic [WORD_W-1:0] r_seed_high, n_seed_high;
    logic [WORD_W-1:0] r_a, n_a;
    logic [WORD_W-1:0] r_b, n_b;
    logic              r_seeded, n_seeded;
    t_kind             r_kind, n_kind;
    logic [WORD_W-1:0] r_min, n_min;
    logic [WORD_W-1:0] r_span, n_span;
    logic [WORD_W-1:0] r_word, n_word;
    logic [WORD_W-1:0] r_w0, n_w0;
    logic              r_second, n_second;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_rsp, n_rsp;

    logic [WORD_W-1:0] cur_a;
    logic [WORD_W-1:0] cur_b;
    logic [WORD_W-1:0] s0x;
    logic [WORD_W-1:0] nb;
    logic [WORD_W-1:0] word;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_diff;
    logic [WORD_W-1:0] uhi;
    logic [WORD_W-1:0] ulo;
    logic              out_free;

    always_comb begin
        if (r_seeded) begin
            cur_a = r_a;
            cur_b = r_b;
        end else begin
            cur_b = r_seed_high;
            cur_a = ((r_seed_low | r_seed_high) == '0) ? SEED_FALLBACK : r_seed_low;
        end
        s0x      = cur_a ^ (cur_a << SHIFT_A);
        nb       = s0x ^ cur_b ^ (s0x >> SHIFT_B) ^ (cur_b >> SHIFT_C);
        word     = nb + cur_b;
        rem_sh   = {r_rem, r_word[WORD_W-1]};
        rem_diff = rem_sh - {1'b0, r_span};
        uhi      = swap_bytes(r_w0);
        ulo      = swap_bytes(r_word);
        uhi[15:8]              = (uhi[15:8] & UUID_VER_MASK) | UUID_VER;
        ulo[WORD_W-1 -: 8]     = (ulo[WORD_W-1 -: 8] & UUID_VAR_MASK) | UUID_VAR;
    end

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_seed_low  = r_seed_low;
        n_seed_high = r_seed_high;
        n_a         = r_a;
        n_b         = r_b;
        n_seeded    = r_seeded;
        n_kind      = r_kind;
        n_min       = r_min;
        n_span      = r_span;
        n_word      = r_word;
        n_w0        = r_w0;
        n_second    = r_second;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_rsp       = r_rsp;
        o_cmd_pop   = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_kind    = i_cmd.kind;
                    n_min     = i_cmd.range_min;
                    n_span    = i_cmd.span;
                    n_second  = 1'b0;
                    if (i_cmd.kind == K_ERR || i_cmd.kind == K_NOP) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DRAW;
                    end
                end
            end
            S_DRAW: begin
                n_a      = cur_b;
                n_b      = nb;
                n_seeded = 1'b1;
                if (r_kind == K_UUID && !r_second) begin
                    n_w0     = word;
                    n_second = 1'b1;
                end else begin
                    n_word = word;
                    if (r_kind == K_RANGE) begin
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (!rem_diff[WORD_W]) begin
                    n_rem = rem_diff[WORD_W-1:0];
                end else begin
                    n_rem = rem_sh[WORD_W-1:0];
                end
                n_word = r_word << 1;
                n_cnt  = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_rsp       = '0;
                    n_state     = S_IDLE;
                    unique case (r_kind)
                        K_RAW:   n_rsp.value = r_word;
                        K_BOOL:  n_rsp.value = {{(WORD_W-1){1'b0}}, r_word[0]};
                        K_RANGE: n_rsp.value = r_min + r_rem;
                        K_FRAC:  n_rsp.value = r_word >> FRAC_DROP;
                        K_UUID: begin
                            n_rsp.uuid_high = uhi;
                            n_rsp.uuid_low  = ulo;
                        end
                        K_ERR:   n_rsp.range_error = 1'b1;
                        K_NOP:   n_rsp = '0;
                        default: n_rsp = '0;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEED_LOW: begin
                    n_seed_low = i_cfg_data;
                    n_seeded   = 1'b0;
                end
                CFG_SEED_HIGH: begin
                    n_seed_high = i_cfg_data;
                    n_seeded    = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed_low  <= SEED_LOW_RST;
            r_seed_high <= SEED_HIGH_RST;
            r_a         <= '0;
            r_b         <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed_low  <= n_seed_low;
            r_seed_high <= n_seed_high;
            r_a         <= n_a;
            r_b         <= n_b;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
        end
        r_kind   <= n_kind;
        r_min    <= n_min;
        r_span   <= n_span;
        r_word   <= n_word;
        r_w0     <= n_w0;
        r_second <= n_second;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_rsp    <= n_rsp;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule
`default_nettype wire

// ===== hw/rtl/xorshift_random_range_unit_top.sv =====
// Channel   Signals                      Direction   Moves
// request   i_valid / o_ready / i_req    in          op, range_min, range_max
// result    o_valid / i_ready / o_rsp    out         value, uuid_high, uuid_low, range_error
// config    i_cfg_we / i_cfg_index / i_cfg_data      seed_low, seed_high
//
// In the back end, raw, boolean and fraction requests draw a word and then finish; uuid draws a
// first and a second word; range adds a divide state: the remainder comes from a radix-2 divider,
// one bit a cycle. Range errors and unused ops finish straight away and draw no word.
// Synchronous active-low reset; no clearing pass.
// The front stage and queue keep taking requests while the back end works
// or its output register waits on i_ready, until the queue fills.
`default_nettype none
module xorshift_random_range_unit_top
    import xrru_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_req                  i_req,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_rsp                       o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic f_cmd_valid;
    t_cmd f_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    xrru_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_cmd_valid (f_cmd_valid),
        .i_cmd_full  (q_full),
        .o_cmd       (f_cmd)
    );

    xrru_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_cmd_valid),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    xrru_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp)
    );

endmodule
`default_nettype wire
